// File: rtl/core/pla_pkg.sv
package pla_pkg;

    // default sizes
    localparam int MAX_POINTS_DEF = 256;
    localparam int NDOF_DEF       = 6;

    // fixed widths of the command bus
    localparam int IDX_W  = 13;
    localparam int AXIS_W = 3;

    // actions
    localparam logic [1:0] ACT_CLEAR   = 2'd0;
    localparam logic [1:0] ACT_APPEND  = 2'd1;
    localparam logic [1:0] ACT_QUERY   = 2'd2;
    localparam logic [1:0] ACT_IMPROVE = 2'd3;

    // result status
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // datapath operations
    localparam logic [4:0] OP_NONE       = 5'd0;
    localparam logic [4:0] OP_LOAD       = 5'd1;
    localparam logic [4:0] OP_CLEAR      = 5'd2;
    localparam logic [4:0] OP_ABSQ       = 5'd3;
    localparam logic [4:0] OP_MUL_SQ     = 5'd4;
    localparam logic [4:0] OP_ACC        = 5'd5;
    localparam logic [4:0] OP_SQRT_INIT  = 5'd6;
    localparam logic [4:0] OP_SQRT_STEP  = 5'd7;
    localparam logic [4:0] OP_ADD_LEN    = 5'd8;
    localparam logic [4:0] OP_SAVE_D     = 5'd9;
    localparam logic [4:0] OP_LO         = 5'd10;
    localparam logic [4:0] OP_HI         = 5'd11;
    localparam logic [4:0] OP_IMP_CMP    = 5'd12;
    localparam logic [4:0] OP_DIV_INIT   = 5'd13;
    localparam logic [4:0] OP_DIV_STEP   = 5'd14;
    localparam logic [4:0] OP_CAP_A      = 5'd15;
    localparam logic [4:0] OP_DIFF       = 5'd16;
    localparam logic [4:0] OP_MUL_RATIO  = 5'd17;
    localparam logic [4:0] OP_RES        = 5'd18;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] coord_0;
        logic signed [31:0] coord_1;
        logic signed [31:0] coord_2;
        logic signed [31:0] coord_3;
        logic signed [31:0] coord_4;
        logic signed [31:0] coord_5;
        logic [31:0]        arc_position;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_0;
        logic signed [31:0] out_1;
        logic signed [31:0] out_2;
        logic signed [31:0] out_3;
        logic signed [31:0] out_4;
        logic signed [31:0] out_5;
        logic               could_improve;
        logic [31:0]        total_length;
    } t_out_item;

    typedef struct packed {
        logic [4:0]        op;
        logic [IDX_W-1:0]  idx;
        logic [AXIS_W-1:0] axis;
        logic              first;
        logic              wp_rd;
        logic              wp_wr;
        logic              len_rd;
        logic              len_wr;
        logic              finish;
        logic [1:0]        status;
    } t_cmd;

    typedef struct packed {
        logic arc_zero;
        logic arc_ge_total;
        logic len_gt_arc;
        logic imp_hit;
    } t_sts;

endpackage

// File: rtl/core/pla_ram.sv
module pla_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/core/pla_datapath.sv
module pla_datapath #(
    parameter int MAX_POINTS = 256,
    parameter int NDOF       = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pla_pkg::t_cmd       i_cmd,
    input  pla_pkg::t_in_item   i_in_item,
    input  logic                i_cfg_valid,
    input  logic [2:0]          i_cfg_data,
    output pla_pkg::t_sts       o_sts,
    output pla_pkg::t_out_item  o_out_item
);
    import pla_pkg::*;

    localparam int LAW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int WAW  = (MAX_POINTS * NDOF > 1) ? $clog2(MAX_POINTS * NDOF) : 1;
    localparam int AXW  = (NDOF > 1) ? $clog2(NDOF) : 1;

    logic [2:0]         r_axes;
    logic [31:0]        r_arc;
    logic [31:0]        r_q [NDOF];
    logic [31:0]        r_total;
    logic [31:0]        r_lo;
    logic [31:0]        r_hi;
    logic [31:0]        r_a;
    logic [31:0]        r_mag;
    logic               r_neg;
    logic [63:0]        r_prod;
    logic [63:0]        r_sum;
    logic [63:0]        r_sv;
    logic [34:0]        r_srem;
    logic [31:0]        r_root;
    logic [31:0]        r_drem;
    logic [31:0]        r_den;
    logic [31:0]        r_ratio;
    logic [31:0]        r_len;
    logic [31:0]        r_dsave;
    logic [31:0]        r_res [NDOF];
    logic               r_improve;
    t_out_item          r_out;

    logic [WAW-1:0]     wp_addr;
    logic [LAW-1:0]     len_addr;
    logic [31:0]        wp_rdata;
    logic [31:0]        len_rdata;
    logic [AXW-1:0]     ax;
    logic               axis_on;
    logic [31:0]        in_coord [6];
    logic [31:0]        res_full [6];
    logic [31:0]        mul_a;
    logic [63:0]        mul_p;
    logic [32:0]        dq;
    logic [32:0]        dd;
    logic [64:0]        acc_sum;
    logic [32:0]        len_sum;
    logic [34:0]        sq_sh;
    logic [34:0]        sq_trial;
    logic [32:0]        dv_sh;
    logic [31:0]        offset;

    // memory addressing
    assign ax       = i_cmd.axis[AXW-1:0];
    assign len_addr = i_cmd.idx[LAW-1:0];
    assign wp_addr  = WAW'(len_addr) * WAW'(NDOF) + WAW'(ax);
    assign axis_on  = i_cmd.axis < r_axes;

    pla_ram #(.WIDTH(32), .DEPTH(MAX_POINTS * NDOF)) u_wp_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wp_wr),
        .i_waddr (wp_addr),
        .i_wdata (r_q[ax]),
        .i_raddr (wp_addr),
        .o_rdata (wp_rdata)
    );

    pla_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.len_wr),
        .i_waddr (len_addr),
        .i_wdata (r_len),
        .i_raddr (len_addr),
        .o_rdata (len_rdata)
    );

    // input coordinates as an array
    always_comb begin
        in_coord[0] = i_in_item.coord_0;
        in_coord[1] = i_in_item.coord_1;
        in_coord[2] = i_in_item.coord_2;
        in_coord[3] = i_in_item.coord_3;
        in_coord[4] = i_in_item.coord_4;
        in_coord[5] = i_in_item.coord_5;
    end

    // arithmetic helpers
    assign mul_a    = (i_cmd.op == OP_MUL_RATIO) ? r_ratio : r_mag;
    assign mul_p    = {32'd0, mul_a} * {32'd0, r_mag};
    assign dq       = {r_q[ax][31], r_q[ax]} - {wp_rdata[31], wp_rdata};
    assign dd       = {wp_rdata[31], wp_rdata} - {r_a[31], r_a};
    assign acc_sum  = {1'b0, r_sum} + {1'b0, r_prod};
    assign len_sum  = {1'b0, len_rdata} + {1'b0, r_root};
    assign sq_sh    = {r_srem[32:0], r_sv[63:62]};
    assign sq_trial = {1'b0, r_root, 2'b01};
    assign dv_sh    = {r_drem, 1'b0};
    assign offset   = r_prod[63:32];

    // status to the controller
    assign o_sts.arc_zero     = (r_arc == 32'd0);
    assign o_sts.arc_ge_total = (r_arc >= r_total);
    assign o_sts.len_gt_arc   = (len_rdata > r_arc);
    assign o_sts.imp_hit      = (({1'b0, r_dsave} + {1'b0, r_root}) < {1'b0, (r_hi - r_lo)});

    // configuration register and path length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axes  <= 3'd6;
            r_total <= 32'd0;
        end else begin
            if (i_cfg_valid) begin
                r_axes <= i_cfg_data;
            end
            if (i_cmd.op == OP_CLEAR) begin
                r_total <= 32'd0;
            end else if (i_cmd.len_wr) begin
                r_total <= r_len;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_arc     <= i_in_item.arc_position;
                r_lo      <= 32'd0;
                r_ratio   <= 32'd0;
                r_len     <= 32'd0;
                r_improve <= 1'b0;
                for (int j = 0; j < NDOF; j++) begin
                    r_q[j]   <= in_coord[j];
                    r_res[j] <= 32'd0;
                end
            end
            OP_ABSQ: begin
                r_mag <= !axis_on ? 32'd0 : (dq[32] ? 32'(-dq) : dq[31:0]);
            end
            OP_MUL_SQ, OP_MUL_RATIO: begin
                r_prod <= mul_p;
            end
            OP_ACC: begin
                if (i_cmd.first) begin
                    r_sum <= r_prod;
                end else begin
                    r_sum <= acc_sum[64] ? {64{1'b1}} : acc_sum[63:0];
                end
            end
            OP_SQRT_INIT: begin
                r_sv   <= r_sum;
                r_srem <= 35'd0;
                r_root <= 32'd0;
            end
            OP_SQRT_STEP: begin
                r_sv <= {r_sv[61:0], 2'b00};
                if (sq_sh >= sq_trial) begin
                    r_srem <= sq_sh - sq_trial;
                    r_root <= {r_root[30:0], 1'b1};
                end else begin
                    r_srem <= sq_sh;
                    r_root <= {r_root[30:0], 1'b0};
                end
            end
            OP_ADD_LEN: begin
                r_len <= len_sum[32] ? 32'hFFFF_FFFF : len_sum[31:0];
            end
            OP_SAVE_D: begin
                r_dsave <= r_root;
            end
            OP_LO: begin
                r_lo <= len_rdata;
            end
            OP_HI: begin
                r_hi <= len_rdata;
            end
            OP_IMP_CMP: begin
                if (o_sts.imp_hit) begin
                    r_improve <= 1'b1;
                end
            end
            OP_DIV_INIT: begin
                r_drem  <= r_arc - r_lo;
                r_den   <= r_hi - r_lo;
                r_ratio <= 32'd0;
            end
            OP_DIV_STEP: begin
                if (dv_sh >= {1'b0, r_den}) begin
                    r_drem  <= 32'(dv_sh - {1'b0, r_den});
                    r_ratio <= {r_ratio[30:0], 1'b1};
                end else begin
                    r_drem  <= dv_sh[31:0];
                    r_ratio <= {r_ratio[30:0], 1'b0};
                end
            end
            OP_CAP_A: begin
                r_a <= wp_rdata;
            end
            OP_DIFF: begin
                r_neg <= dd[32];
                r_mag <= dd[32] ? 32'(-dd) : dd[31:0];
            end
            OP_RES: begin
                r_res[ax] <= !axis_on ? 32'd0 : (r_neg ? r_a - offset : r_a + offset);
            end
            default: begin
            end
        endcase
    end

    // result transaction
    always_comb begin
        for (int j = 0; j < 6; j++) begin
            res_full[j] = 32'd0;
        end
        for (int j = 0; j < NDOF; j++) begin
            res_full[j] = r_res[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.status        <= i_cmd.status;
            r_out.out_0         <= res_full[0];
            r_out.out_1         <= res_full[1];
            r_out.out_2         <= res_full[2];
            r_out.out_3         <= res_full[3];
            r_out.out_4         <= res_full[4];
            r_out.out_5         <= res_full[5];
            r_out.could_improve <= r_improve;
            r_out.total_length  <= r_total;
        end
    end

    assign o_out_item = r_out;
endmodule

// File: rtl/core/pla_ctrl.sv
module pla_ctrl #(
    parameter int MAX_POINTS = 256,
    parameter int NDOF       = 6
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [1:0]     i_action,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    input  pla_pkg::t_sts  i_sts,
    output pla_pkg::t_cmd  o_cmd
);
    import pla_pkg::*;

    localparam int CW = $clog2(MAX_POINTS + 1);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_DISP    = 5'd1;
    localparam logic [4:0] S_WWR     = 5'd2;
    localparam logic [4:0] S_WLEN    = 5'd3;
    localparam logic [4:0] S_DRD     = 5'd4;
    localparam logic [4:0] S_DSUB    = 5'd5;
    localparam logic [4:0] S_DMUL    = 5'd6;
    localparam logic [4:0] S_DACC    = 5'd7;
    localparam logic [4:0] S_SQI     = 5'd8;
    localparam logic [4:0] S_SQS     = 5'd9;
    localparam logic [4:0] S_DDONE   = 5'd10;
    localparam logic [4:0] S_AADD    = 5'd11;
    localparam logic [4:0] S_IMP_RD0 = 5'd12;
    localparam logic [4:0] S_IMP_RD1 = 5'd13;
    localparam logic [4:0] S_IMP_HI  = 5'd14;
    localparam logic [4:0] S_QRD     = 5'd15;
    localparam logic [4:0] S_QCHK    = 5'd16;
    localparam logic [4:0] S_DVI     = 5'd17;
    localparam logic [4:0] S_DVS     = 5'd18;
    localparam logic [4:0] S_IRD_A   = 5'd19;
    localparam logic [4:0] S_IRD_B   = 5'd20;
    localparam logic [4:0] S_IDIF    = 5'd21;
    localparam logic [4:0] S_IMUL    = 5'd22;
    localparam logic [4:0] S_IRES    = 5'd23;
    localparam logic [4:0] S_FIN     = 5'd24;

    localparam logic [1:0] CTX_APP  = 2'd0;
    localparam logic [1:0] CTX_IMP1 = 2'd1;
    localparam logic [1:0] CTX_IMP2 = 2'd2;

    localparam logic [AXIS_W-1:0] AX_LAST = AXIS_W'(NDOF - 1);

    logic [4:0]        r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_widx, n_widx;
    logic [CW-1:0]     r_seg_lo, n_seg_lo;
    logic [CW-1:0]     r_seg_hi, n_seg_hi;
    logic [AXIS_W-1:0] r_axis, n_axis;
    logic [4:0]        r_iter, n_iter;
    logic [1:0]        r_dctx, n_dctx;
    logic [1:0]        r_status, n_status;
    logic [1:0]        r_action, n_action;
    logic              r_out_valid, n_out_valid;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_widx   <= n_widx;
        r_seg_lo <= n_seg_lo;
        r_seg_hi <= n_seg_hi;
        r_axis   <= n_axis;
        r_iter   <= n_iter;
        r_dctx   <= n_dctx;
        r_status <= n_status;
        r_action <= n_action;
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_widx      = r_widx;
        n_seg_lo    = r_seg_lo;
        n_seg_hi    = r_seg_hi;
        n_axis      = r_axis;
        n_iter      = r_iter;
        n_dctx      = r_dctx;
        n_status    = r_status;
        n_action    = r_action;
        n_out_valid = r_out_valid && i_out_stall;

        o_cmd        = '0;
        o_cmd.op     = OP_NONE;
        o_cmd.axis   = r_axis;
        o_cmd.status = r_status;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_action = i_action;
                    n_status = ST_OK;
                    n_axis   = '0;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                case (r_action)
                    ACT_CLEAR: begin
                        o_cmd.op = OP_CLEAR;
                        n_count  = '0;
                        n_state  = S_FIN;
                    end
                    ACT_APPEND: begin
                        if (r_count >= CW'(MAX_POINTS)) begin
                            n_status = ST_FULL;
                            n_state  = S_FIN;
                        end else begin
                            n_state = S_WWR;
                        end
                    end
                    ACT_QUERY: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_FIN;
                        end else if (i_sts.arc_zero) begin
                            n_seg_lo = '0;
                            n_seg_hi = '0;
                            n_state  = S_IRD_A;
                        end else if (i_sts.arc_ge_total) begin
                            n_seg_lo = r_count - 1'b1;
                            n_seg_hi = r_count - 1'b1;
                            n_state  = S_IRD_A;
                        end else begin
                            n_idx   = CW'(1);
                            n_state = S_QRD;
                        end
                    end
                    default: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_FIN;
                        end else if (r_count < CW'(3)) begin
                            n_state = S_FIN;
                        end else begin
                            n_idx   = CW'(1);
                            n_state = S_IMP_RD0;
                        end
                    end
                endcase
            end
            // append: store coordinates, then distance to previous waypoint
            S_WWR: begin
                o_cmd.wp_wr = 1'b1;
                o_cmd.idx   = IDX_W'(r_count);
                if (r_axis == AX_LAST) begin
                    n_axis = '0;
                    if (r_count == '0) begin
                        n_state = S_WLEN;
                    end else begin
                        n_widx  = r_count - 1'b1;
                        n_dctx  = CTX_APP;
                        n_state = S_DRD;
                    end
                end else begin
                    n_axis = r_axis + 1'b1;
                end
            end
            S_WLEN: begin
                o_cmd.len_wr = 1'b1;
                o_cmd.idx    = IDX_W'(r_count);
                n_count      = r_count + 1'b1;
                n_state      = S_FIN;
            end
            // shared distance unit: per axis read, difference, square, sum
            S_DRD: begin
                o_cmd.wp_rd = 1'b1;
                o_cmd.idx   = IDX_W'(r_widx);
                n_state     = S_DSUB;
            end
            S_DSUB: begin
                o_cmd.op = OP_ABSQ;
                n_state  = S_DMUL;
            end
            S_DMUL: begin
                o_cmd.op = OP_MUL_SQ;
                n_state  = S_DACC;
            end
            S_DACC: begin
                o_cmd.op    = OP_ACC;
                o_cmd.first = (r_axis == '0);
                if (r_axis == AX_LAST) begin
                    n_state = S_SQI;
                end else begin
                    n_axis  = r_axis + 1'b1;
                    n_state = S_DRD;
                end
            end
            S_SQI: begin
                o_cmd.op = OP_SQRT_INIT;
                n_iter   = '0;
                n_state  = S_SQS;
            end
            S_SQS: begin
                o_cmd.op = OP_SQRT_STEP;
                n_iter   = r_iter + 1'b1;
                if (r_iter == 5'd31) begin
                    n_state = S_DDONE;
                end
            end
            S_DDONE: begin
                case (r_dctx)
                    CTX_APP: begin
                        o_cmd.len_rd = 1'b1;
                        o_cmd.idx    = IDX_W'(r_count - 1'b1);
                        n_state      = S_AADD;
                    end
                    CTX_IMP1: begin
                        o_cmd.op = OP_SAVE_D;
                        n_widx   = r_idx - 1'b1;
                        n_axis   = '0;
                        n_dctx   = CTX_IMP2;
                        n_state  = S_DRD;
                    end
                    default: begin
                        o_cmd.op = OP_IMP_CMP;
                        if (i_sts.imp_hit || (r_idx + CW'(2) >= r_count)) begin
                            n_state = S_FIN;
                        end else begin
                            n_idx   = r_idx + 1'b1;
                            n_state = S_IMP_RD0;
                        end
                    end
                endcase
            end
            S_AADD: begin
                o_cmd.op = OP_ADD_LEN;
                n_state  = S_WLEN;
            end
            // improve test: lengths around interior waypoint, then two distances
            S_IMP_RD0: begin
                o_cmd.len_rd = 1'b1;
                o_cmd.idx    = IDX_W'(r_idx - 1'b1);
                n_state      = S_IMP_RD1;
            end
            S_IMP_RD1: begin
                o_cmd.op     = OP_LO;
                o_cmd.len_rd = 1'b1;
                o_cmd.idx    = IDX_W'(r_idx + 1'b1);
                n_state      = S_IMP_HI;
            end
            S_IMP_HI: begin
                o_cmd.op = OP_HI;
                n_widx   = r_idx + 1'b1;
                n_axis   = '0;
                n_dctx   = CTX_IMP1;
                n_state  = S_DRD;
            end
            // query: find the segment holding the arc position
            S_QRD: begin
                o_cmd.len_rd = 1'b1;
                o_cmd.idx    = IDX_W'(r_idx);
                n_state      = S_QCHK;
            end
            S_QCHK: begin
                if (i_sts.len_gt_arc) begin
                    o_cmd.op = OP_HI;
                    n_seg_lo = r_idx - 1'b1;
                    n_seg_hi = r_idx;
                    n_state  = S_DVI;
                end else begin
                    o_cmd.op = OP_LO;
                    n_idx    = r_idx + 1'b1;
                    n_state  = S_QRD;
                end
            end
            S_DVI: begin
                o_cmd.op = OP_DIV_INIT;
                n_iter   = '0;
                n_state  = S_DVS;
            end
            S_DVS: begin
                o_cmd.op = OP_DIV_STEP;
                n_iter   = r_iter + 1'b1;
                if (r_iter == 5'd31) begin
                    n_axis  = '0;
                    n_state = S_IRD_A;
                end
            end
            // interpolate each axis between the segment ends
            S_IRD_A: begin
                o_cmd.wp_rd = 1'b1;
                o_cmd.idx   = IDX_W'(r_seg_lo);
                n_state     = S_IRD_B;
            end
            S_IRD_B: begin
                o_cmd.op    = OP_CAP_A;
                o_cmd.wp_rd = 1'b1;
                o_cmd.idx   = IDX_W'(r_seg_hi);
                n_state     = S_IDIF;
            end
            S_IDIF: begin
                o_cmd.op = OP_DIFF;
                n_state  = S_IMUL;
            end
            S_IMUL: begin
                o_cmd.op = OP_MUL_RATIO;
                n_state  = S_IRES;
            end
            S_IRES: begin
                o_cmd.op = OP_RES;
                if (r_axis == AX_LAST) begin
                    n_state = S_FIN;
                end else begin
                    n_axis  = r_axis + 1'b1;
                    n_state = S_IRD_A;
                end
            end
            // hand the result to the output register
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
endmodule

// File: rtl/core/polyline_arc_length_interpolator.sv
// Polyline store with arc-length interpolation. One transaction is taken at a
// time; its result goes to an output register so the next transaction may be
// taken while that result waits. Append stores the coordinates, then runs one
// distance through the shared square/accumulate unit and a 32-step square
// root. Query does a linear walk over the running lengths, a 32-step divider
// and a per-axis multiply; an endpoint query skips the walk and the divider.
// Improve test examines the interior waypoints in turn, stopping at the first
// shortcut. Axes are read in turn from the single-port waypoint memory, and
// distances and interpolation share the one 32x32 multiplier. The
// configuration register (axes in use) may only be written while the block is
// idle.
module polyline_arc_length_interpolator #(
    parameter int MAX_POINTS = pla_pkg::MAX_POINTS_DEF,
    parameter int NDOF       = pla_pkg::NDOF_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  pla_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output pla_pkg::t_out_item o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_data
);
    import pla_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // configuration always taken
    assign o_cfg_ready = 1'b1;

    pla_ctrl #(.MAX_POINTS(MAX_POINTS), .NDOF(NDOF)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_in_item.action),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pla_datapath #(.MAX_POINTS(MAX_POINTS), .NDOF(NDOF)) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_sts       (sts),
        .o_out_item  (o_out_item)
    );
endmodule

// File: dv/tb_polyline_arc_length_interpolator.sv
module tb_polyline_arc_length_interpolator;
    timeunit 1ns;
    timeprecision 1ps;
    import pla_pkg::*;

    localparam int NPTS = 256;
    localparam int NAX  = 6;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    t_in_item           i_in_item;
    logic               o_out_valid;
    logic               i_out_stall;
    t_out_item          o_out_item;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_data;

    polyline_arc_length_interpolator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // shadow copy of the path
    logic signed [31:0] path_pts [NPTS][NAX];
    logic [31:0]        path_len [NPTS];
    int unsigned        path_cnt;
    logic [2:0]         axes_reg;

    t_in_item    pending_q [$];
    t_out_item   expected_q [$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          n_errors;
    int          n_checked;
    int          n_queries;
    int          n_improves;
    int          n_full;
    bit          cfg_req;
    logic [2:0]  cfg_val;

    function automatic int unsigned live_axes();
        return (axes_reg > NAX) ? NAX : axes_reg;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // euclidean distance over the active axes, saturated to 32 bits
    function automatic logic [31:0] seg_dist(logic signed [31:0] a [NAX],
                                             logic signed [31:0] b [NAX]);
        logic [63:0]        s;
        logic [63:0]        m;
        logic [63:0]        sq;
        logic signed [63:0] d;
        logic [63:0]        r;
        s = 0;
        for (int j = 0; j < live_axes(); j++) begin
            d = 64'(a[j]) - 64'(b[j]);
            m = (d < 0) ? 64'(-d) : 64'(d);
            sq = m * m;
            s = (s > 64'hFFFF_FFFF_FFFF_FFFF - sq) ? 64'hFFFF_FFFF_FFFF_FFFF : s + sq;
        end
        r = int_sqrt(s);
        return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
    endfunction

    // advance the shadow path by one transaction and return its result
    function automatic t_out_item path_apply(t_in_item it);
        t_out_item          o;
        logic signed [31:0] q [NAX];
        logic signed [31:0] res [NAX];
        logic [63:0]        t;
        logic [63:0]        num;
        logic [63:0]        den;
        logic [63:0]        ratio;
        logic [63:0]        m;
        logic [63:0]        prod;
        logic signed [63:0] d;
        logic signed [63:0] off;
        logic [63:0]        delta;
        logic [63:0]        tst;
        int unsigned        last;
        q = '{it.coord_0, it.coord_1, it.coord_2, it.coord_3, it.coord_4, it.coord_5};
        res = '{default: 0};
        o = '0;
        o.status = ST_OK;
        case (it.action)
            ACT_CLEAR: begin
                path_cnt = 0;
            end
            ACT_APPEND: begin
                if (path_cnt >= NPTS) begin
                    o.status = ST_FULL;
                    n_full++;
                end else begin
                    path_pts[path_cnt] = q;
                    if (path_cnt == 0) begin
                        path_len[0] = 0;
                    end else begin
                        t = 64'(path_len[path_cnt-1]) +
                            64'(seg_dist(path_pts[path_cnt-1], path_pts[path_cnt]));
                        path_len[path_cnt] = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
                    end
                    path_cnt++;
                end
            end
            default: begin
                if (path_cnt == 0) begin
                    o.status = ST_EMPTY;
                end else if (it.action == ACT_QUERY) begin
                    last = path_cnt - 1;
                    if (it.arc_position == 0) begin
                        res = path_pts[0];
                    end else if (it.arc_position >= path_len[last]) begin
                        res = path_pts[last];
                    end else begin
                        res = path_pts[last];
                        for (int i = 1; i < path_cnt; i++) begin
                            if (path_len[i] > it.arc_position) begin
                                num = 64'(32'(it.arc_position - path_len[i-1]));
                                den = 64'(32'(path_len[i] - path_len[i-1]));
                                ratio = (num << 32) / den;
                                for (int j = 0; j < NAX; j++) begin
                                    d = 64'(path_pts[i][j]) - 64'(path_pts[i-1][j]);
                                    m = (d < 0) ? 64'(-d) : 64'(d);
                                    prod = ratio * m;
                                    off = 64'(prod >> 32);
                                    if (d < 0) off = -off;
                                    res[j] = 32'(64'(path_pts[i-1][j]) + off);
                                end
                                break;
                            end
                        end
                    end
                    for (int j = live_axes(); j < NAX; j++) res[j] = 0;
                end else begin
                    for (int i = 1; i + 1 < path_cnt; i++) begin
                        delta = 64'(32'(path_len[i+1] - path_len[i-1]));
                        tst = 64'(seg_dist(path_pts[i+1], q)) +
                              64'(seg_dist(path_pts[i-1], q));
                        if (tst < delta) begin
                            o.could_improve = 1'b1;
                            break;
                        end
                    end
                end
            end
        endcase
        o.out_0 = res[0];
        o.out_1 = res[1];
        o.out_2 = res[2];
        o.out_3 = res[3];
        o.out_4 = res[4];
        o.out_5 = res[5];
        o.total_length = path_cnt ? path_len[path_cnt-1] : 32'd0;
        return o;
    endfunction

    function automatic logic signed [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            2: return ($urandom_range(0, 1)) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
        endcase
    endfunction

    function automatic t_in_item mk_item(logic [1:0] act, int mode, logic [31:0] arc);
        t_in_item it;
        it.action = act;
        it.coord_0 = rand_coord(mode);
        it.coord_1 = rand_coord(mode);
        it.coord_2 = rand_coord(mode);
        it.coord_3 = rand_coord(mode);
        it.coord_4 = rand_coord(mode);
        it.coord_5 = rand_coord(mode);
        it.arc_position = arc;
        return it;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) expected_q.push_back(path_apply(i_in_item));
            if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_item  <= pending_q.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // configuration write
    always @(posedge i_clk) begin
        if (i_cfg_valid && o_cfg_ready) begin
            axes_reg    <= i_cfg_data;
            i_cfg_valid <= 1'b0;
            cfg_req     <= 1'b0;
        end else if (cfg_req && !i_cfg_valid) begin
            i_cfg_valid <= 1'b1;
            i_cfg_data  <= cfg_val;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                $display("%0t unexpected result: actual %p", $realtime, o_out_item);
                n_errors++;
            end else begin
                exp_item = expected_q.pop_front();
                n_checked++;
                if (exp_item.status != o_out_item.status ||
                    exp_item.out_0 != o_out_item.out_0 ||
                    exp_item.out_1 != o_out_item.out_1 ||
                    exp_item.out_2 != o_out_item.out_2 ||
                    exp_item.out_3 != o_out_item.out_3 ||
                    exp_item.out_4 != o_out_item.out_4 ||
                    exp_item.out_5 != o_out_item.out_5 ||
                    exp_item.could_improve != o_out_item.could_improve ||
                    exp_item.total_length != o_out_item.total_length) begin
                    $display("%0t result mismatch: expected %p actual %p",
                             $realtime, exp_item, o_out_item);
                    n_errors++;
                end
            end
        end
    end

    task automatic drain();
        while (pending_q.size() > 0 || i_in_valid || expected_q.size() > 0)
            @(posedge i_clk);
        repeat (4000) @(posedge i_clk);
    endtask

    task automatic write_axes(logic [2:0] v);
        cfg_val = v;
        cfg_req = 1'b1;
        while (cfg_req) @(posedge i_clk);
    endtask

    // a short path of nearby points then queries and improve tests on it
    task automatic queue_path_phase(int n_items);
        int          k;
        int          mode;
        logic [31:0] arc;
        k = 0;
        while (k < n_items) begin
            mode = ($urandom_range(0, 9) == 0) ? 0 : 1;
            if ($urandom_range(0, 3) != 0) pending_q.push_back(mk_item(ACT_CLEAR, 0, $urandom));
            for (int p = $urandom_range(0, 6); p > 0; p--) begin
                pending_q.push_back(mk_item(ACT_APPEND, mode, $urandom));
                k++;
            end
            for (int p = $urandom_range(1, 6); p > 0; p--) begin
                case ($urandom_range(0, 3))
                    0: arc = 0;
                    1: arc = $urandom;
                    default: arc = $urandom_range(0, 32'h0010_0000);
                endcase
                pending_q.push_back(mk_item(($urandom_range(0, 1)) ? ACT_QUERY : ACT_IMPROVE,
                                            ($urandom_range(0, 3) == 0) ? 0 : 1, arc));
                k++;
            end
        end
    endtask

    // directed and random stimulus
    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        axes_reg = 3'd6;
        path_cnt = 0;
        cfg_req = 1'b0;
        cfg_val = '0;
        n_errors = 0;
        n_checked = 0;
        n_queries = 0;
        n_improves = 0;
        n_full = 0;
        send_idle_pct = 13;
        recv_idle_pct = 51;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty path answers, extreme coordinates, segment walk and shortcut
        pending_q.push_back(mk_item(ACT_QUERY, 0, 32'h10));
        pending_q.push_back(mk_item(ACT_IMPROVE, 0, 0));
        pending_q.push_back(mk_item(ACT_APPEND, 2, 0));
        pending_q.push_back(mk_item(ACT_QUERY, 0, 0));
        pending_q.push_back(mk_item(ACT_APPEND, 2, 0));
        pending_q.push_back(mk_item(ACT_APPEND, 2, 0));
        pending_q.push_back(mk_item(ACT_QUERY, 0, 32'hFFFF_FFFF));
        pending_q.push_back(mk_item(ACT_QUERY, 0, 32'h8000_0000));
        pending_q.push_back(mk_item(ACT_IMPROVE, 2, 0));
        pending_q.push_back(mk_item(ACT_CLEAR, 0, 0));
        for (int p = 0; p < 5; p++) pending_q.push_back(mk_item(ACT_APPEND, 1, 0));
        pending_q.push_back(mk_item(ACT_QUERY, 1, 32'h0002_0000));
        pending_q.push_back(mk_item(ACT_QUERY, 1, 32'h0000_0001));
        pending_q.push_back(mk_item(ACT_IMPROVE, 1, 0));
        pending_q.push_back(mk_item(ACT_IMPROVE, 3, 0));
        pending_q.push_back(mk_item(ACT_CLEAR, 0, 0));
        drain();

        // fill the store past its capacity
        write_axes(3'd1);
        for (int p = 0; p < NPTS + 3; p++) pending_q.push_back(mk_item(ACT_APPEND, 1, 0));
        pending_q.push_back(mk_item(ACT_QUERY, 1, 32'h0008_0000));
        pending_q.push_back(mk_item(ACT_CLEAR, 0, 0));
        drain();

        // random phases over axis settings and idle mixes
        write_axes(3'd0);
        queue_path_phase(40);
        drain();
        write_axes(3'd7);
        queue_path_phase(40);
        drain();
        send_idle_pct = 51;
        recv_idle_pct = 13;
        write_axes(3'd3);
        queue_path_phase(60);
        drain();
        write_axes(3'd2);
        queue_path_phase(40);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_axes(3'd6);
        queue_path_phase(60);
        drain();
        write_axes(3'd4);
        queue_path_phase(30);
        drain();
        write_axes(3'd5);
        queue_path_phase(30);
        drain();

        $display("checked %0d results across clear, append, query and improve tests,",
                 n_checked);
        $display("axis counts 0 to 7, a full store and three stall mixes");
        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // hang guard
    initial begin
        #80ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // count query and improve requests accepted by the block
    always @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            if (i_in_item.action == ACT_QUERY) n_queries++;
            if (i_in_item.action == ACT_IMPROVE) n_improves++;
        end
    end
endmodule
